// File: design/urss_pkg.sv
// Shared types, codes and constants of the UI refresh slot scheduler.
package urss_pkg;

  localparam int MAX_FIGURES_DEF     = 32;
  localparam int MAX_TEXTS_DEF       = 16;
  localparam int SLOTS_PER_FRAME_DEF = 7;
  localparam logic [15:0] SEND_INTERVAL_RST = 16'd100;

  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0,
    KIND_ACK   = 2'd1,
    KIND_CMD   = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_FIGURE_COUNT  = 2'd0,
    REG_TEXT_COUNT    = 2'd1,
    REG_FIGURE_CLASS  = 2'd2,
    REG_SEND_INTERVAL = 2'd3
  } reg_t;

  typedef enum logic [3:0] {
    CMD_RST_ALL   = 4'd0,
    CMD_RST_FIGS  = 4'd1,
    CMD_RST_TXTS  = 4'd2,
    CMD_RST_FIG   = 4'd3,
    CMD_RST_TXT   = 4'd4,
    CMD_HIDE_ALL  = 4'd5,
    CMD_HIDE_FIGS = 4'd6,
    CMD_HIDE_TXTS = 4'd7,
    CMD_HIDE_FIG  = 4'd8,
    CMD_HIDE_TXT  = 4'd9,
    CMD_SHOW_ALL  = 4'd10,
    CMD_SHOW_FIGS = 4'd11,
    CMD_SHOW_TXTS = 4'd12,
    CMD_SHOW_FIG  = 4'd13,
    CMD_SHOW_TXT  = 4'd14,
    CMD_NOP       = 4'd15
  } cmd_t;

  typedef enum logic [1:0] {
    CLS_ONCE     = 2'd0,
    CLS_REALTIME = 2'd1,
    CLS_QUEUED   = 2'd2,
    CLS_NONE     = 2'd3
  } cls_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_MODIFY = 2'd2,
    ACT_DELETE = 2'd3
  } act_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_EXEC,
    OP_START,
    OP_RESTART,
    OP_SCAN_ONCE,
    OP_SCAN_TEXT,
    OP_SCAN_RT,
    OP_SCAN_QALL,
    OP_SCAN_QRR,
    OP_EMIT_FIG,
    OP_EMIT_TEXT,
    OP_EMIT_NONE
  } op_t;

  typedef struct packed {
    op_t op;
  } ctl_t;

  typedef struct packed {
    kind_t kind;
    logic  time_ok;
    logic  once_done;
    logic  text_done;
    logic  text_found;
    logic  rt_done;
    logic  qall_done;
    logic  qrr_done;
    logic  used_zero;
    logic  q_go;
    logic  q_all;
    logic  emit_last;
    logic  out_free;
  } sts_t;

endpackage

// File: design/urss_req_if.sv
// Request channel: one scheduler event.
interface urss_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [31:0] now_ms;
  logic [3:0] command;
  logic [4:0] target_index;
  modport source(output valid, kind, now_ms, command, target_index, input ready);
  modport sink(input valid, kind, now_ms, command, target_index, output ready);
endinterface

// File: design/urss_res_if.sv
// Result channel: one frame pick.
interface urss_res_if;
  logic       valid;
  logic       ready;
  logic       has_frame;
  logic       frame_kind;
  logic [4:0] entry_index;
  logic [1:0] action;
  logic       last;
  modport source(output valid, has_frame, frame_kind, entry_index, action, last,
                 input ready);
  modport sink(input valid, has_frame, frame_kind, entry_index, action, last,
               output ready);
endinterface

// File: design/urss_cfg_if.sv
// Configuration write channel.
interface urss_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: design/urss_ctrl.sv
// Sequencer of the scheduler: walks the scan phases and result emission.
module urss_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_fire,
  output logic           req_ready,
  input  urss_pkg::sts_t sts,
  output urss_pkg::ctl_t ctl
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_ONCE, S_TEXT, S_RT, S_Q, S_QALL, S_QRR,
    S_EMIT, S_EMIT_TEXT, S_EMIT_NONE
  } state_t;

  state_t state, state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctl.op     = urss_pkg::OP_NOP;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          ctl.op     = urss_pkg::OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.kind == urss_pkg::KIND_FRAME) begin
          ctl.op     = urss_pkg::OP_START;
          state_next = sts.time_ok ? S_ONCE : S_EMIT_NONE;
        end else begin
          ctl.op     = urss_pkg::OP_EXEC;
          state_next = S_IDLE;
        end
      end
      S_ONCE: begin
        ctl.op = urss_pkg::OP_SCAN_ONCE;
        if (sts.once_done) begin
          if (sts.used_zero) begin
            ctl.op     = urss_pkg::OP_RESTART;
            state_next = S_TEXT;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_TEXT: begin
        ctl.op = urss_pkg::OP_SCAN_TEXT;
        if (sts.text_done) begin
          if (sts.text_found) begin
            state_next = S_EMIT_TEXT;
          end else begin
            ctl.op     = urss_pkg::OP_RESTART;
            state_next = S_RT;
          end
        end
      end
      S_RT: begin
        ctl.op = urss_pkg::OP_SCAN_RT;
        if (sts.rt_done) begin
          ctl.op     = urss_pkg::OP_RESTART;
          state_next = S_Q;
        end
      end
      S_Q: begin
        if (sts.q_go) state_next = sts.q_all ? S_QALL : S_QRR;
        else          state_next = sts.used_zero ? S_EMIT_NONE : S_EMIT;
      end
      S_QALL: begin
        ctl.op = urss_pkg::OP_SCAN_QALL;
        if (sts.qall_done) state_next = S_EMIT;
      end
      S_QRR: begin
        ctl.op = urss_pkg::OP_SCAN_QRR;
        if (sts.qrr_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          ctl.op = urss_pkg::OP_EMIT_FIG;
          if (sts.emit_last) state_next = S_IDLE;
        end
      end
      S_EMIT_TEXT: begin
        if (sts.out_free) begin
          ctl.op     = urss_pkg::OP_EMIT_TEXT;
          state_next = S_IDLE;
        end
      end
      S_EMIT_NONE: begin
        if (sts.out_free) begin
          ctl.op     = urss_pkg::OP_EMIT_NONE;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

// File: design/urss_dp.sv
// Datapath of the scheduler: marks, registers, scan counters, picks, result register.
module urss_dp #(
  parameter int MAX_FIGURES     = urss_pkg::MAX_FIGURES_DEF,
  parameter int MAX_TEXTS       = urss_pkg::MAX_TEXTS_DEF,
  parameter int SLOTS_PER_FRAME = urss_pkg::SLOTS_PER_FRAME_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  urss_pkg::ctl_t ctl,
  output urss_pkg::sts_t sts,
  input  logic [1:0]     in_kind,
  input  logic [31:0]    in_now,
  input  logic [3:0]     in_command,
  input  logic [4:0]     in_target,
  input  logic           cfg_fire,
  input  logic [1:0]     cfg_index,
  input  logic [63:0]    cfg_data,
  input  logic           out_ready,
  output logic           out_valid,
  output logic           out_has_frame,
  output logic           out_frame_kind,
  output logic [4:0]     out_entry_index,
  output logic [1:0]     out_action,
  output logic           out_last
);

  localparam int FIW = (MAX_FIGURES > 1) ? $clog2(MAX_FIGURES) : 1;
  localparam int TIW = (MAX_TEXTS > 1) ? $clog2(MAX_TEXTS) : 1;
  localparam int UW  = $clog2(SLOTS_PER_FRAME + 1);
  localparam int PW  = (SLOTS_PER_FRAME > 1) ? $clog2(SLOTS_PER_FRAME) : 1;
  localparam logic [UW-1:0] SLOTS = UW'(SLOTS_PER_FRAME);

  logic [MAX_FIGURES-1:0] fig_plotted, fig_hidden;
  logic [MAX_TEXTS-1:0]   txt_plotted, txt_hidden;
  logic [5:0]  figure_count;
  logic [4:0]  text_count;
  logic [63:0] figure_classes;
  logic [15:0] send_interval;
  logic [31:0] last_send;
  logic [4:0]  queue_ptr;

  logic [1:0]  kind;
  logic [31:0] now_ms;
  logic [3:0]  command;
  logic [4:0]  target;

  logic [5:0]    scan_i, scan_k, queued;
  logic [4:0]    pos;
  logic [UW-1:0] used, emit_k;
  logic          found;
  logic [TIW-1:0] txt_sel;
  logic [4:0]    pick [SLOTS_PER_FRAME];

  function automatic logic [1:0] cls(input logic [63:0] c, input logic [4:0] i);
    return c[{i, 1'b0} +: 2];
  endfunction

  logic [31:0] elapsed;
  logic        room_left;
  logic [1:0]  cls_i, cls_pos;
  logic [5:0]  pos_inc, qp_inc, room;
  logic [4:0]  emit_f;
  logic        emit_p, emit_h, tx_p, tx_h;
  logic        emit_now;

  assign elapsed   = now_ms - last_send;
  assign room_left = used < SLOTS;
  assign cls_i     = cls(figure_classes, scan_i[4:0]);
  assign cls_pos   = cls(figure_classes, pos);
  assign pos_inc   = {1'b0, pos} + 6'd1;
  assign qp_inc    = {1'b0, queue_ptr} + 6'd1;
  assign room      = 6'(SLOTS - used);
  assign emit_f    = pick[emit_k[PW-1:0]];
  assign emit_p    = fig_plotted[emit_f[FIW-1:0]];
  assign emit_h    = fig_hidden[emit_f[FIW-1:0]];
  assign tx_p      = txt_plotted[txt_sel];
  assign tx_h      = txt_hidden[txt_sel];
  assign emit_now  = (ctl.op == urss_pkg::OP_EMIT_FIG) || (ctl.op == urss_pkg::OP_EMIT_TEXT) ||
                     (ctl.op == urss_pkg::OP_EMIT_NONE);

  always_comb begin
    sts.kind       = urss_pkg::kind_t'(kind);
    sts.time_ok    = elapsed > {16'd0, send_interval};
    sts.once_done  = !(scan_i < figure_count && room_left);
    sts.text_found = found;
    sts.text_done  = found || !(scan_i < {1'b0, text_count});
    sts.rt_done    = !(scan_i < figure_count);
    sts.qall_done  = !(scan_i < figure_count);
    sts.qrr_done   = !(scan_k < figure_count && room_left);
    sts.used_zero  = (used == '0);
    sts.q_go       = room_left && (queued != 6'd0);
    sts.q_all      = room >= queued;
    sts.emit_last  = (emit_k + UW'(1)) == used;
    sts.out_free   = !out_valid || out_ready;
  end

  function automatic logic [1:0] decide(input logic p, input logic h);
    if (h) return p ? urss_pkg::ACT_DELETE : urss_pkg::ACT_NONE;
    return p ? urss_pkg::ACT_MODIFY : urss_pkg::ACT_ADD;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      fig_plotted    <= '0;
      fig_hidden     <= '0;
      txt_plotted    <= '0;
      txt_hidden     <= '0;
      figure_count   <= '0;
      text_count     <= '0;
      figure_classes <= '0;
      send_interval  <= urss_pkg::SEND_INTERVAL_RST;
      last_send      <= '0;
      queue_ptr      <= '0;
      out_valid      <= 1'b0;
      used           <= '0;
      emit_k         <= '0;
      found          <= 1'b0;
    end else begin
      if (out_valid && out_ready && !emit_now) out_valid <= 1'b0;

      if (cfg_fire) begin
        unique case (urss_pkg::reg_t'(cfg_index))
          urss_pkg::REG_FIGURE_COUNT:
            figure_count <= (32'(cfg_data[5:0]) > MAX_FIGURES) ? 6'(MAX_FIGURES)
                                                                 : cfg_data[5:0];
          urss_pkg::REG_TEXT_COUNT:
            text_count <= (32'(cfg_data[4:0]) > MAX_TEXTS) ? 5'(MAX_TEXTS)
                                                             : cfg_data[4:0];
          urss_pkg::REG_FIGURE_CLASS:  figure_classes <= cfg_data;
          urss_pkg::REG_SEND_INTERVAL: send_interval  <= cfg_data[15:0];
          default: ;
        endcase
      end

      case (ctl.op)
        urss_pkg::OP_LOAD: begin
          kind    <= in_kind;
          now_ms  <= in_now;
          command <= in_command;
          target  <= in_target;
        end
        urss_pkg::OP_EXEC: begin
          if (kind == urss_pkg::KIND_ACK) last_send <= now_ms;
          if (kind == urss_pkg::KIND_CMD) begin
            unique case (urss_pkg::cmd_t'(command))
              urss_pkg::CMD_RST_ALL: begin
                for (int i = 0; i < MAX_FIGURES; i++)
                  if (i < 32'(figure_count)) fig_plotted[i] <= 1'b0;
                for (int i = 0; i < MAX_TEXTS; i++)
                  if (i < 32'(text_count)) txt_plotted[i] <= 1'b0;
              end
              urss_pkg::CMD_RST_FIGS: fig_plotted <= '0;
              urss_pkg::CMD_RST_TXTS: txt_plotted <= '0;
              urss_pkg::CMD_RST_FIG:
                if (32'(target) < MAX_FIGURES) fig_plotted[target[FIW-1:0]] <= 1'b0;
              urss_pkg::CMD_RST_TXT:
                if (32'(target) < MAX_TEXTS) txt_plotted[TIW'(target)] <= 1'b0;
              urss_pkg::CMD_HIDE_ALL: begin
                fig_hidden <= '1;
                txt_hidden <= '1;
              end
              urss_pkg::CMD_HIDE_FIGS: fig_hidden <= '1;
              urss_pkg::CMD_HIDE_TXTS: txt_hidden <= '1;
              urss_pkg::CMD_HIDE_FIG:
                if (32'(target) < MAX_FIGURES) fig_hidden[target[FIW-1:0]] <= 1'b1;
              urss_pkg::CMD_HIDE_TXT:
                if (32'(target) < MAX_TEXTS) txt_hidden[TIW'(target)] <= 1'b1;
              urss_pkg::CMD_SHOW_ALL: begin
                fig_hidden <= '0;
                txt_hidden <= '0;
              end
              urss_pkg::CMD_SHOW_FIGS: fig_hidden <= '0;
              urss_pkg::CMD_SHOW_TXTS: txt_hidden <= '0;
              urss_pkg::CMD_SHOW_FIG:
                if (32'(target) < MAX_FIGURES) fig_hidden[target[FIW-1:0]] <= 1'b0;
              urss_pkg::CMD_SHOW_TXT:
                if (32'(target) < MAX_TEXTS) txt_hidden[TIW'(target)] <= 1'b0;
              default: ;
            endcase
          end
        end
        urss_pkg::OP_START: begin
          scan_i <= '0;
          queued <= '0;
          used   <= '0;
          emit_k <= '0;
          found  <= 1'b0;
        end
        urss_pkg::OP_RESTART: begin
          scan_i <= '0;
          scan_k <= '0;
          pos    <= (qp_inc >= figure_count) ? 5'd0 : qp_inc[4:0];
        end
        urss_pkg::OP_SCAN_ONCE: begin
          if (!sts.once_done) begin
            if (cls_i == urss_pkg::CLS_ONCE && !fig_plotted[scan_i[FIW-1:0]] &&
                !fig_hidden[scan_i[FIW-1:0]]) begin
              pick[used[PW-1:0]] <= scan_i[4:0];
              used <= used + UW'(1);
            end
            scan_i <= scan_i + 6'd1;
          end
        end
        urss_pkg::OP_SCAN_TEXT: begin
          if (!sts.text_done) begin
            if (!txt_plotted[scan_i[TIW-1:0]] && !txt_hidden[scan_i[TIW-1:0]]) begin
              found   <= 1'b1;
              txt_sel <= scan_i[TIW-1:0];
            end else begin
              scan_i <= scan_i + 6'd1;
            end
          end
        end
        urss_pkg::OP_SCAN_RT: begin
          if (!sts.rt_done) begin
            if (cls_i == urss_pkg::CLS_REALTIME && room_left) begin
              pick[used[PW-1:0]] <= scan_i[4:0];
              used <= used + UW'(1);
            end else if (cls_i == urss_pkg::CLS_QUEUED) begin
              queued <= queued + 6'd1;
            end
            scan_i <= scan_i + 6'd1;
          end
        end
        urss_pkg::OP_SCAN_QALL: begin
          if (!sts.qall_done) begin
            if (cls_i == urss_pkg::CLS_QUEUED && room_left) begin
              pick[used[PW-1:0]] <= scan_i[4:0];
              used <= used + UW'(1);
            end
            scan_i <= scan_i + 6'd1;
          end
        end
        urss_pkg::OP_SCAN_QRR: begin
          if (!sts.qrr_done) begin
            if (cls_pos == urss_pkg::CLS_QUEUED) begin
              pick[used[PW-1:0]] <= pos;
              used      <= used + UW'(1);
              queue_ptr <= pos;
            end
            pos    <= (pos_inc >= figure_count) ? 5'd0 : pos_inc[4:0];
            scan_k <= scan_k + 6'd1;
          end
        end
        urss_pkg::OP_EMIT_FIG: begin
          out_valid       <= 1'b1;
          out_has_frame   <= 1'b1;
          out_frame_kind  <= 1'b0;
          out_entry_index <= emit_f;
          out_action      <= decide(emit_p, emit_h);
          out_last        <= sts.emit_last;
          fig_plotted[emit_f[FIW-1:0]] <= !emit_h;
          emit_k          <= emit_k + UW'(1);
        end
        urss_pkg::OP_EMIT_TEXT: begin
          out_valid       <= 1'b1;
          out_has_frame   <= 1'b1;
          out_frame_kind  <= 1'b1;
          out_entry_index <= 5'(txt_sel);
          out_action      <= decide(tx_p, tx_h);
          out_last        <= 1'b1;
          txt_plotted[txt_sel] <= !tx_h;
        end
        urss_pkg::OP_EMIT_NONE: begin
          out_valid       <= 1'b1;
          out_has_frame   <= 1'b0;
          out_frame_kind  <= 1'b0;
          out_entry_index <= 5'd0;
          out_action      <= urss_pkg::ACT_NONE;
          out_last        <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: design/ui_refresh_slot_scheduler.sv
// Top level of the UI refresh slot scheduler: sequencer plus datapath.
// A request is loaded, then dispatched: an acknowledge or command executes directly. A frame
//   request past the send interval runs the scans in order (once, text, real-time, queued),
//   ending early when the once scan picks or a text is found, then emits its result(s).
// Throughput: one request at a time, set by the scans; the next is taken while the last result waits.
// Reset (rst, synchronous): marks clear, queue pointer and last send time zero, registers reset.
module ui_refresh_slot_scheduler #(
  parameter int MAX_FIGURES     = urss_pkg::MAX_FIGURES_DEF,
  parameter int MAX_TEXTS       = urss_pkg::MAX_TEXTS_DEF,
  parameter int SLOTS_PER_FRAME = urss_pkg::SLOTS_PER_FRAME_DEF
) (
  input logic       clk,
  input logic       rst,
  urss_req_if.sink  req,
  urss_res_if.source res,
  urss_cfg_if.sink  cfg
);

  urss_pkg::ctl_t ctl;
  urss_pkg::sts_t sts;
  logic           req_ready;

  // Registers are to be written only while idle; the block does not enforce this and always takes the write.
  assign cfg.ready = 1'b1;
  assign req.ready = req_ready;

  // Sequence the request through its scan phases.
  urss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_fire  (req.valid && req_ready),
    .req_ready (req_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // Hold marks and registers, advance scans, drive the result register.
  urss_dp #(
    .MAX_FIGURES     (MAX_FIGURES),
    .MAX_TEXTS       (MAX_TEXTS),
    .SLOTS_PER_FRAME (SLOTS_PER_FRAME)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .sts             (sts),
    .in_kind         (req.kind),
    .in_now          (req.now_ms),
    .in_command      (req.command),
    .in_target       (req.target_index),
    .cfg_fire        (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .out_ready       (res.ready),
    .out_valid       (res.valid),
    .out_has_frame   (res.has_frame),
    .out_frame_kind  (res.frame_kind),
    .out_entry_index (res.entry_index),
    .out_action      (res.action),
    .out_last        (res.last)
  );

endmodule

// File: bench/ui_refresh_slot_scheduler_tb.sv
// Self-checking bench for the UI refresh slot scheduler: random requests, predicted picks.
module ui_refresh_slot_scheduler_tb;

  typedef struct packed {
    urss_pkg::kind_t kind;
    logic [31:0]     now_ms;
    logic [3:0]      command;
    logic [4:0]      target_index;
  } sched_req_t;

  typedef struct packed {
    logic       has_frame;
    logic       frame_kind;
    logic [4:0] entry_index;
    logic [1:0] action;
    logic       last;
  } pick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  urss_req_if req ();
  urss_res_if res ();
  urss_cfg_if cfg ();

  ui_refresh_slot_scheduler uut (.clk(clk), .rst(rst), .req(req), .res(res), .cfg(cfg));

  // Mirror of the scheduler's marks and registers.
  logic [31:0] fig_plotted, fig_hidden;
  logic [15:0] txt_plotted, txt_hidden;
  int unsigned rr_ptr;
  logic [31:0] last_ack_ms;
  int unsigned fig_count, txt_count;
  logic [63:0] fig_classes;
  logic [15:0] interval_ms;

  sched_req_t  pending_reqs[$];
  pick_t       expected_picks[$];
  int          errors = 0;
  int          send_idle_pct = 30;
  int          recv_idle_pct = 63;
  int          hold_left = 0;
  bit          send_hold = 1'b0;
  bit          req_taken = 1'b0;
  logic [31:0] clock_ms = 32'd0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic urss_pkg::cls_t class_of(int unsigned i);
    return urss_pkg::cls_t'(fig_classes[2*i +: 2]);
  endfunction

  function automatic urss_pkg::act_t fig_action(int unsigned i);
    if (fig_hidden[i]) begin
      if (fig_plotted[i]) begin
        fig_plotted[i] = 1'b0;
        return urss_pkg::ACT_DELETE;
      end
      return urss_pkg::ACT_NONE;
    end
    if (fig_plotted[i]) return urss_pkg::ACT_MODIFY;
    fig_plotted[i] = 1'b1;
    return urss_pkg::ACT_ADD;
  endfunction

  task automatic push_pick(logic h, logic fk, int unsigned idx, urss_pkg::act_t a, logic l);
    pick_t p;
    p.has_frame = h;
    p.frame_kind = fk;
    p.entry_index = idx[4:0];
    p.action = a;
    p.last = l;
    expected_picks.push_back(p);
  endtask

  // Apply a display command to the mirrored marks.
  task automatic apply_command(urss_pkg::cmd_t c, logic [4:0] idx);
    int unsigned grp, sub;
    bit hide_mark, v;
    if (c == urss_pkg::CMD_NOP) return;
    grp = c / 5;
    sub = c % 5;
    hide_mark = (grp != 0);
    v = (grp == 1);
    if (c == urss_pkg::CMD_RST_ALL) begin
      for (int i = 0; i < fig_count; i++) fig_plotted[i] = 1'b0;
      for (int i = 0; i < txt_count; i++) txt_plotted[i] = 1'b0;
      return;
    end
    if (sub == 0 || sub == 1) begin
      if (hide_mark) fig_hidden = {32{v}}; else fig_plotted = {32{v}};
    end
    if (sub == 0 || sub == 2) begin
      if (hide_mark) txt_hidden = {16{v}}; else txt_plotted = {16{v}};
    end
    if (sub == 3) begin
      if (hide_mark) fig_hidden[idx] = v; else fig_plotted[idx] = v;
    end
    if (sub == 4 && idx < 16) begin
      if (hide_mark) txt_hidden[idx[3:0]] = v; else txt_plotted[idx[3:0]] = v;
    end
  endtask

  // Work out the picks of one frame request.
  task automatic predict_frame(logic [31:0] now);
    int unsigned sel[$];
    int unsigned queued, pos;
    logic [31:0] since;
    since = now - last_ack_ms;
    if (since > {16'd0, interval_ms}) begin
      for (int i = 0; i < fig_count && sel.size() < 7; i++)
        if (class_of(i) == urss_pkg::CLS_ONCE && !fig_plotted[i] && !fig_hidden[i])
          sel.push_back(i);
      if (sel.size() == 0) begin
        for (int i = 0; i < txt_count; i++) begin
          if (!txt_plotted[i] && !txt_hidden[i]) begin
            txt_plotted[i] = 1'b1;
            push_pick(1'b1, 1'b1, i, urss_pkg::ACT_ADD, 1'b1);
            return;
          end
        end
        queued = 0;
        for (int i = 0; i < fig_count; i++) begin
          if (class_of(i) == urss_pkg::CLS_REALTIME && sel.size() < 7) sel.push_back(i);
          else if (class_of(i) == urss_pkg::CLS_QUEUED) queued++;
        end
        if (sel.size() < 7 && queued > 0) begin
          if (7 - sel.size() >= queued) begin
            for (int i = 0; i < fig_count; i++)
              if (class_of(i) == urss_pkg::CLS_QUEUED) sel.push_back(i);
          end else begin
            pos = (rr_ptr + 1 >= fig_count) ? 0 : rr_ptr + 1;
            for (int k = 0; k < fig_count && sel.size() < 7; k++) begin
              if (class_of(pos) == urss_pkg::CLS_QUEUED) begin
                sel.push_back(pos);
                rr_ptr = pos;
              end
              pos = (pos + 1 >= fig_count) ? 0 : pos + 1;
            end
          end
        end
      end
    end
    if (sel.size() == 0) begin
      push_pick(1'b0, 1'b0, 0, urss_pkg::ACT_NONE, 1'b1);
      return;
    end
    foreach (sel[k]) push_pick(1'b1, 1'b0, sel[k], fig_action(sel[k]), k == sel.size() - 1);
  endtask

  task automatic predict(sched_req_t r);
    case (r.kind)
      urss_pkg::KIND_FRAME: predict_frame(r.now_ms);
      urss_pkg::KIND_ACK:   last_ack_ms = r.now_ms;
      urss_pkg::KIND_CMD:   apply_command(urss_pkg::cmd_t'(r.command), r.target_index);
      default: ;
    endcase
  endtask

  // Acceptance: predict each request at the edge that takes it.
  always @(posedge clk) begin
    if (!rst && req.valid && req.ready) begin
      predict(pending_reqs.pop_front());
      req_taken = 1'b1;
    end
  end

  // Driver: offer queued requests at the falling edge, hold until taken.
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req_taken) begin
      req_taken = 1'b0;
      if (pending_reqs.size() > 0 && !send_hold &&
          $urandom_range(99) >= send_idle_pct) begin
        req.valid <= 1'b1;
        req.kind <= pending_reqs[0].kind;
        req.now_ms <= pending_reqs[0].now_ms;
        req.command <= pending_reqs[0].command;
        req.target_index <= pending_reqs[0].target_index;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random, or hold off for a counted stretch.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each accepted pick with the oldest prediction.
  always @(posedge clk) begin
    pick_t want;
    if (!rst && res.valid && res.ready) begin
      if (expected_picks.size() == 0) begin
        $error("unexpected pick idx=%0d", res.entry_index);
        errors++;
      end else begin
        want = expected_picks.pop_front();
        if (res.has_frame !== want.has_frame) begin
          $error("has_frame exp %0d got %0d", want.has_frame, res.has_frame); errors++;
        end
        if (res.frame_kind !== want.frame_kind) begin
          $error("frame_kind exp %0d got %0d", want.frame_kind, res.frame_kind); errors++;
        end
        if (res.entry_index !== want.entry_index) begin
          $error("entry_index exp %0d got %0d", want.entry_index, res.entry_index); errors++;
        end
        if (res.action !== want.action) begin
          $error("action exp %0d got %0d", want.action, res.action); errors++;
        end
        if (res.last !== want.last) begin
          $error("last exp %0d got %0d", want.last, res.last); errors++;
        end
      end
    end
  end

  // Write one register while the block is idle and mirror it.
  task automatic write_reg(urss_pkg::reg_t r, logic [63:0] d);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= r;
    cfg.data <= d;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
    case (r)
      urss_pkg::REG_FIGURE_COUNT:  fig_count = (d[5:0] > 32) ? 32 : d[5:0];
      urss_pkg::REG_TEXT_COUNT:    txt_count = (d[4:0] > 16) ? 16 : d[4:0];
      urss_pkg::REG_FIGURE_CLASS:  fig_classes = d;
      default:                     interval_ms = d[15:0];
    endcase
  endtask

  task automatic add_req(urss_pkg::kind_t k, logic [31:0] t, logic [3:0] c, logic [4:0] idx);
    sched_req_t r;
    r.kind = k;
    r.now_ms = t;
    r.command = c;
    r.target_index = idx;
    pending_reqs.push_back(r);
  endtask

  // Time jumps mostly past the interval, sometimes short of it.
  task automatic add_frame();
    clock_ms += (($urandom_range(3) == 0) ? $urandom_range(interval_ms) :
                 interval_ms + 1 + $urandom_range(50));
    if ($urandom_range(19) == 0) clock_ms = $urandom;
    add_req(urss_pkg::KIND_FRAME, clock_ms, 4'd0, 5'd0);
  endtask

  task automatic add_random();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) add_frame();
    else if (pick < 65) begin
      clock_ms += $urandom_range(20);
      add_req(urss_pkg::KIND_ACK, clock_ms, 4'd0, 5'd0);
    end else if (pick < 97) begin
      add_req(urss_pkg::KIND_CMD, $urandom, 4'($urandom_range(15)), 5'($urandom_range(31)));
    end else add_req(urss_pkg::KIND_NONE, $urandom, 4'($urandom), 5'($urandom));
  endtask

  // Wait until every request is in and every pick is out, then settle.
  task automatic drain();
    while (pending_reqs.size() > 0 || req.valid || expected_picks.size() > 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  initial begin
    fig_plotted = '0; fig_hidden = '0; txt_plotted = '0; txt_hidden = '0;
    rr_ptr = 0; last_ack_ms = '0; fig_count = 0; txt_count = 0;
    fig_classes = '0; interval_ms = urss_pkg::SEND_INTERVAL_RST;
    req.valid = 1'b0; req.kind = urss_pkg::KIND_NONE; req.now_ms = '0;
    req.command = '0; req.target_index = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0; cfg.index = urss_pkg::REG_FIGURE_COUNT; cfg.data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset-state frames, clamped register writes, extreme times, then every command with extreme indexes.
    add_req(urss_pkg::KIND_FRAME, 32'd100, 4'd0, 5'd0);
    add_req(urss_pkg::KIND_FRAME, 32'd101, 4'd0, 5'd0);
    drain();
    write_reg(urss_pkg::REG_FIGURE_COUNT, 64'd63);
    write_reg(urss_pkg::REG_TEXT_COUNT, 64'd31);
    write_reg(urss_pkg::REG_FIGURE_CLASS, 64'h9999_5555_0000_FFFF);
    write_reg(urss_pkg::REG_SEND_INTERVAL, 64'd0);
    clock_ms = 32'd200;
    add_req(urss_pkg::KIND_ACK, 32'hFFFF_FFFF, 4'd0, 5'd0);
    add_req(urss_pkg::KIND_FRAME, 32'hFFFF_FFFF, 4'd0, 5'd0);
    add_req(urss_pkg::KIND_FRAME, 32'd0, 4'd0, 5'd0);
    for (int c = 0; c < 16; c++)
      add_req(urss_pkg::KIND_CMD, 32'd0, c[3:0], (c % 2) ? 5'd31 : 5'd0);
    add_req(urss_pkg::KIND_NONE, 32'hFFFF_FFFF, 4'hF, 5'h1F);
    add_req(urss_pkg::KIND_FRAME, 32'd5, 4'd0, 5'd0);
    add_req(urss_pkg::KIND_FRAME, 32'd6, 4'd0, 5'd0);
    drain();

    // Random phases under varied settings; idling pattern changes at phases 2 and 4.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin send_idle_pct = 63; recv_idle_pct = 30; end
      if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
      write_reg(urss_pkg::REG_FIGURE_COUNT, (ph == 5) ? 64'd32 : $urandom_range(40));
      write_reg(urss_pkg::REG_TEXT_COUNT, (ph == 5) ? 64'd0 : $urandom_range(20));
      write_reg(urss_pkg::REG_FIGURE_CLASS, {$urandom, $urandom});
      write_reg(urss_pkg::REG_SEND_INTERVAL, (ph == 3) ? 64'd65535 : $urandom_range(60));
      clock_ms = last_ack_ms;
      if (ph == 1) begin
        // Hold off the receiver so the block backs up its input.
        hold_left = 400;
        repeat (20) add_frame();
      end
      for (int n = 0; n < 56; n++) begin
        add_random();
        if (n == 28) begin
          // Pause the sender until everything already sent is answered.
          while (pending_reqs.size() > 0 || req.valid) @(posedge clk);
          send_hold = 1'b1;
          while (expected_picks.size() > 0) @(posedge clk);
          send_hold = 1'b0;
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("ui_refresh_slot_scheduler_tb: clean");
    end else begin
      $display("ui_refresh_slot_scheduler_tb: errors");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("ui_refresh_slot_scheduler_tb: errors");
    $finish;
  end

endmodule
